### design/qph_pkg.sv
// qph_pkg: shared constants, codes and transaction types for the
// quadratic probe hash table core. depends on nothing.

package qph_pkg;

  // table geometry
  localparam int unsigned TableSize = 127;                 // prime slot count
  localparam int unsigned SlotW     = $clog2(TableSize);
  localparam int unsigned StepW     = $clog2(TableSize + 1);
  localparam int unsigned HalfLoad  = TableSize / 2;

  // field widths
  localparam int unsigned KeyW      = 32;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned RankW     = 7;
  localparam int unsigned ByteCount = KeyW / 8;
  localparam int unsigned EntryW    = 2 + KeyW + ValueW;
  localparam int unsigned CmpW      = ((SlotW > RankW) ? SlotW : RankW) + 1;

  typedef enum logic [2:0] {
    KindInsert   = 3'd0,
    KindRemove   = 3'd1,
    KindFind     = 3'd2,
    KindRetrieve = 3'd3,
    KindClear    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    StatusNew  = 2'd0,
    StatusHit  = 2'd1,
    StatusMiss = 2'd2,
    StatusFull = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TagFree = 2'd0,
    TagDead = 2'd1,
    TagLive = 2'd2
  } tag_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
    logic [RankW-1:0]  rank;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [KeyW-1:0]   found_key;
    logic [ValueW-1:0] found_value;
    logic [6:0]        slot;
    logic [5:0]        active_total;
  } rsp_t;

  typedef struct packed {
    logic [1:0]        tag;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } entry_t;

endpackage

### design/qph_ram.sv
// qph_ram: generic single-write, single-read synchronous ram with
// registered read data. no package dependency.

module qph_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/qph_mod.sv
// qph_mod: home slot unit, key mod table size, one key byte per cycle
// by shift-and-reduce. depends on qph_pkg.

module qph_mod
  import qph_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KeyW-1:0]  key_i,
  output logic             done_o,
  output logic [SlotW-1:0] rem_o
);

  localparam int unsigned XW   = SlotW + 8;
  localparam int unsigned CntW = $clog2(ByteCount + 1);

  logic [KeyW-1:0]  key_q;
  logic [SlotW-1:0] acc_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [XW-1:0]    x;

  // acc * 256 + byte stays below 256 * TableSize, so eight restoring steps finish it
  always_comb begin
    x = {acc_q, key_q[KeyW-1 -: 8]};
    for (int j = 7; j >= 0; j--) begin
      if (x >= (XW'(TableSize) << j)) begin
        x = x - (XW'(TableSize) << j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        key_q  <= key_i;
        acc_q  <= '0;
        cnt_q  <= CntW'(ByteCount);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= x[SlotW-1:0];
        key_q <= key_q << 8;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = acc_q;

endmodule

### design/quadratic_probe_hash_table_core.sv
// quadratic_probe_hash_table_core: open-addressing hash table, quadratic
// probing, tombstones. depends on qph_pkg, qph_ram and qph_mod.
//
//   channel   handshake              payload  direction
//   request   start high, busy low   req_i    in
//   result    done_o, one cycle      rsp_o    out
//
// insert, remove, find: the accept cycle, the home slot reduction, one ram
// read, then one slot per cycle from the ram read port. retrieve walks the
// slots from slot zero, at most the whole table; clear, bad kind and
// out-of-range rank finish in the accept cycle. the result is registered and
// shows in the cycle after the operation finishes, and a new transaction can
// be taken in that cycle. reset clears the slot valid bits at once, no
// clearing pass. the receiver cannot stall, so busy depends only on the
// operation in flight.

module quadratic_probe_hash_table_core
  import qph_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_WALK
  } state_e;

  state_e                 state_q, state_d;
  req_t                   req_q, req_d;
  logic [SlotW-1:0]       p_q, p_d;         // slot under test
  logic [SlotW-1:0]       inc_q, inc_d;     // next probe distance, (2k-1) mod size
  logic [StepW-1:0]       k_q, k_d;         // probe step number from 1
  logic                   have_dead_q, have_dead_d;
  logic [SlotW-1:0]       dead_q, dead_d;   // first tombstone on the probe
  logic [SlotW-1:0]       idx_q, idx_d;     // retrieve walk position
  logic [SlotW-1:0]       seen_q, seen_d;   // live entries passed in the walk
  logic [SlotW-1:0]       used_q, used_d;
  logic [SlotW-1:0]       active_q, active_d;
  logic [TableSize-1:0]   valid_q, valid_d; // slot written since reset or clear
  rsp_t                   rsp_q, rsp_d;
  logic                   done_q, done_d;

  logic                   accept;
  logic                   mod_start, mod_done;
  logic [SlotW-1:0]       mod_rem;
  logic                   rd_en, wr_en;
  logic [SlotW-1:0]       rd_addr, wr_addr;
  entry_t                 wr_entry, rd_entry;
  logic [EntryW-1:0]      rd_data;

  // probe evaluation of the entry just read
  logic [SlotW-1:0]       cur_slot;
  tag_e                   cur_tag;
  logic                   is_free, is_dead, is_hit, at_limit;
  logic                   have_dead_e;
  logic [SlotW-1:0]       dead_e;
  logic [SlotW:0]         p_sum, inc_sum;
  logic [SlotW-1:0]       p_n, inc_n;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  qph_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .key_i  (req_i.key),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  qph_ram #(
    .Width(EntryW),
    .Depth(TableSize)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_entry),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  // the ram output belongs to p_q while probing and to idx_q while walking
  assign cur_slot = (state_q == S_WALK) ? idx_q : p_q;

  // a slot never written since reset or clear reads as never used
  always_comb begin
    cur_tag = TagFree;
    if (valid_q[cur_slot]) begin
      case (rd_entry.tag)
        TagDead: cur_tag = TagDead;
        TagLive: cur_tag = TagLive;
        default: cur_tag = TagFree;
      endcase
    end
  end

  assign is_free     = (cur_tag == TagFree);
  assign is_dead     = (cur_tag == TagDead);
  assign is_hit      = (cur_tag == TagLive) && (rd_entry.key == req_q.key);
  assign at_limit    = (k_q == StepW'(TableSize));
  assign have_dead_e = have_dead_q || is_dead;
  assign dead_e      = have_dead_q ? dead_q : p_q;

  // next probe slot and distance, each below twice the size so one subtract wraps
  assign p_sum   = {1'b0, p_q} + {1'b0, inc_q};
  assign inc_sum = {1'b0, inc_q} + (SlotW + 1)'(2);
  assign p_n     = (p_sum >= (SlotW + 1)'(TableSize)) ?
                   SlotW'(p_sum - (SlotW + 1)'(TableSize)) : SlotW'(p_sum);
  assign inc_n   = (inc_sum >= (SlotW + 1)'(TableSize)) ?
                   SlotW'(inc_sum - (SlotW + 1)'(TableSize)) : SlotW'(inc_sum);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    p_d         = p_q;
    inc_d       = inc_q;
    k_d         = k_q;
    have_dead_d = have_dead_q;
    dead_d      = dead_q;
    idx_d       = idx_q;
    seen_d      = seen_q;
    used_d      = used_q;
    active_d    = active_q;
    valid_d     = valid_q;
    rsp_d       = rsp_q;
    done_d      = 1'b0;
    mod_start   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = p_q;
    wr_entry    = '{tag: TagLive, key: req_q.key, value: req_q.value};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_i;
          case (req_i.kind)
            KindInsert, KindRemove, KindFind: begin
              mod_start = 1'b1;
              state_d   = S_HASH;
            end
            KindRetrieve: begin
              if ((req_i.rank == '0) || (CmpW'(req_i.rank) > CmpW'(active_q))) begin
                rsp_d        = '0;
                rsp_d.status = StatusMiss;
                done_d       = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                idx_d   = '0;
                seen_d  = '0;
                state_d = S_WALK;
              end
            end
            KindClear: begin
              valid_d      = '0;
              used_d       = '0;
              active_d     = '0;
              rsp_d        = '0;
              rsp_d.status = StatusNew;
              done_d       = 1'b1;
            end
            default: begin
              rsp_d        = '0;
              rsp_d.status = StatusMiss;
              done_d       = 1'b1;
            end
          endcase
        end
      end

      S_HASH: begin
        if (mod_done) begin
          rd_en       = 1'b1;
          rd_addr     = mod_rem;
          p_d         = mod_rem;
          inc_d       = SlotW'(1);
          k_d         = StepW'(1);
          have_dead_d = 1'b0;
          state_d     = S_PROBE;
        end
      end

      S_PROBE: begin
        if (is_free || is_hit || at_limit) begin
          rsp_d   = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (req_q.kind == KindInsert) begin
            if (is_hit) begin
              // replace the value in place
              wr_en             = 1'b1;
              wr_addr           = p_q;
              rsp_d.status      = StatusHit;
              rsp_d.found_key   = req_q.key;
              rsp_d.found_value = req_q.value;
              rsp_d.slot        = 7'(p_q);
            end else if (have_dead_e) begin
              // reuse the first tombstone, used count unchanged
              wr_en             = 1'b1;
              wr_addr           = dead_e;
              active_d          = active_q + 1'b1;
              rsp_d.status      = StatusNew;
              rsp_d.found_key   = req_q.key;
              rsp_d.found_value = req_q.value;
              rsp_d.slot        = 7'(dead_e);
            end else if (is_free) begin
              if ((CmpW'(used_q) + CmpW'(1)) > CmpW'(HalfLoad)) begin
                rsp_d.status = StatusFull;
                rsp_d.slot   = 7'(p_q);
              end else begin
                wr_en             = 1'b1;
                wr_addr           = p_q;
                valid_d[p_q]      = 1'b1;
                used_d            = used_q + 1'b1;
                active_d          = active_q + 1'b1;
                rsp_d.status      = StatusNew;
                rsp_d.found_key   = req_q.key;
                rsp_d.found_value = req_q.value;
                rsp_d.slot        = 7'(p_q);
              end
            end else begin
              // whole probe sequence spent with no slot to take
              rsp_d.status = StatusFull;
            end
          end else begin
            if (is_hit) begin
              rsp_d.status      = StatusHit;
              rsp_d.found_key   = rd_entry.key;
              rsp_d.found_value = rd_entry.value;
              rsp_d.slot        = 7'(p_q);
              if (req_q.kind == KindRemove) begin
                wr_en    = 1'b1;
                wr_addr  = p_q;
                wr_entry = '{tag: TagDead, key: rd_entry.key, value: rd_entry.value};
                active_d = active_q - 1'b1;
              end
            end else begin
              rsp_d.status = StatusMiss;
              if (is_free || have_dead_e) begin
                rsp_d.slot = 7'(dead_e);
              end
            end
          end
        end else begin
          if (is_dead && !have_dead_q) begin
            have_dead_d = 1'b1;
            dead_d      = p_q;
          end
          rd_en   = 1'b1;
          rd_addr = p_n;
          p_d     = p_n;
          inc_d   = inc_n;
          k_d     = k_q + 1'b1;
        end
      end

      S_WALK: begin
        if ((cur_tag == TagLive) &&
            ((CmpW'(seen_q) + CmpW'(1)) == CmpW'(req_q.rank))) begin
          rsp_d             = '0;
          rsp_d.status      = StatusHit;
          rsp_d.found_key   = rd_entry.key;
          rsp_d.found_value = rd_entry.value;
          rsp_d.slot        = 7'(idx_q);
          done_d            = 1'b1;
          state_d           = S_IDLE;
        end else if (idx_q == SlotW'(TableSize - 1)) begin
          rsp_d        = '0;
          rsp_d.status = StatusMiss;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          if (cur_tag == TagLive) begin
            seen_d = seen_q + 1'b1;
          end
          rd_en   = 1'b1;
          rd_addr = idx_q + 1'b1;
          idx_d   = idx_q + 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // count after the operation travels with every result
    if (done_d) begin
      rsp_d.active_total = 6'(active_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      p_q         <= '0;
      inc_q       <= '0;
      k_q         <= '0;
      have_dead_q <= 1'b0;
      dead_q      <= '0;
      idx_q       <= '0;
      seen_q      <= '0;
      used_q      <= '0;
      active_q    <= '0;
      valid_q     <= '0;
      rsp_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      p_q         <= p_d;
      inc_q       <= inc_d;
      k_q         <= k_d;
      have_dead_q <= have_dead_d;
      dead_q      <= dead_d;
      idx_q       <= idx_d;
      seen_q      <= seen_d;
      used_q      <= used_d;
      active_q    <= active_d;
      valid_q     <= valid_d;
      rsp_q       <= rsp_d;
      done_q      <= done_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### design/qph_checker.sv
// qph_props: port-level assertions for the hash table core, bound to
// the top level. depends on qph_pkg.

module qph_props
  import qph_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  // an accepted transaction either finishes next cycle or holds the core busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o || busy)
    else $error("accepted transaction neither finished nor busy");

  // misses and refusals carry no entry
  a_miss_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == StatusMiss || rsp_o.status == StatusFull)
      |-> rsp_o.found_key == '0 && rsp_o.found_value == '0)
    else $error("miss or refusal reported an entry");

  // the load limit bounds the live count
  a_load_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.active_total <= 6'(HalfLoad))
    else $error("active count above half the table");

  // clear answers at once with an empty table
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.kind == KindClear
      |=> done_o && rsp_o.active_total == '0 && rsp_o.status == StatusNew)
    else $error("clear did not empty the table");

endmodule

bind quadratic_probe_hash_table_core qph_props u_qph_props (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .req_i (req_i),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

### verif/qph_checker.sv
// qph_checker: result predictor and scoreboard for the quadratic probe hash
// table core. depends on qph_pkg; watches the request and result channels.

module qph_checker
  import qph_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic busy,
  input  req_t req_i,
  input  logic done_o,
  input  rsp_t rsp_o,
  output int   errors_o,
  output int   pending_o
);

  // shadow copy of the table
  tag_e              shadow_tag [TableSize];
  logic [KeyW-1:0]   shadow_key [TableSize];
  logic [ValueW-1:0] shadow_val [TableSize];
  int                used_cnt;
  int                live_cnt;

  rsp_t expected_rsp_q [$];
  int   mismatch_cnt;

  // walk the probe chain of one key
  function automatic void walk_chain(input logic [KeyW-1:0] k, output int pos,
                                     output bit hit, output bit ok);
    int p;
    int dead;
    bit have_dead;
    p = int'(k % KeyW'(TableSize));
    dead = 0;
    have_dead = 1'b0;
    pos = 0;
    hit = 1'b0;
    ok = 1'b0;
    for (int step = 1; step <= TableSize; step++) begin
      if (shadow_tag[p] == TagFree) begin
        pos = have_dead ? dead : p;
        ok = 1'b1;
        return;
      end
      if (shadow_tag[p] == TagLive) begin
        if (shadow_key[p] == k) begin
          pos = p;
          hit = 1'b1;
          ok = 1'b1;
          return;
        end
      end else if (!have_dead) begin
        have_dead = 1'b1;
        dead = p;
      end
      p = (p + 2 * step - 1) % TableSize;
    end
    pos = dead;
    ok = have_dead;
  endfunction

  // apply one operation to the shadow table and return its result
  function automatic rsp_t apply_op(input req_t r);
    rsp_t o;
    int   pos;
    bit   hit;
    bit   ok;
    int   seen;
    o = '0;
    o.status = StatusMiss;
    pos = 0;
    case (r.kind)
      KindInsert: begin
        walk_chain(r.key, pos, hit, ok);
        if (!ok) begin
          o.status = StatusFull;
          pos = 0;
        end else if (hit) begin
          shadow_val[pos] = r.value;
          o.status = StatusHit;
          o.found_key = r.key;
          o.found_value = r.value;
        end else if (shadow_tag[pos] == TagDead) begin
          shadow_tag[pos] = TagLive;
          shadow_key[pos] = r.key;
          shadow_val[pos] = r.value;
          live_cnt++;
          o.status = StatusNew;
          o.found_key = r.key;
          o.found_value = r.value;
        end else if (used_cnt + 1 > HalfLoad) begin
          o.status = StatusFull;
        end else begin
          shadow_tag[pos] = TagLive;
          shadow_key[pos] = r.key;
          shadow_val[pos] = r.value;
          used_cnt++;
          live_cnt++;
          o.status = StatusNew;
          o.found_key = r.key;
          o.found_value = r.value;
        end
      end
      KindRemove, KindFind: begin
        walk_chain(r.key, pos, hit, ok);
        if (!ok) begin
          pos = 0;
        end else if (hit) begin
          o.status = StatusHit;
          o.found_key = shadow_key[pos];
          o.found_value = shadow_val[pos];
          if (r.kind == KindRemove) begin
            shadow_tag[pos] = TagDead;
            live_cnt--;
          end
        end
      end
      KindRetrieve: begin
        seen = 0;
        if (r.rank != 0) begin
          for (int i = 0; i < TableSize; i++) begin
            if (shadow_tag[i] == TagLive) begin
              seen++;
              if (seen == int'(r.rank)) begin
                o.status = StatusHit;
                o.found_key = shadow_key[i];
                o.found_value = shadow_val[i];
                pos = i;
                break;
              end
            end
          end
        end
      end
      KindClear: begin
        for (int i = 0; i < TableSize; i++) shadow_tag[i] = TagFree;
        used_cnt = 0;
        live_cnt = 0;
        o.status = StatusNew;
      end
      default: ;
    endcase
    o.slot = 7'(pos);
    o.active_total = 6'(live_cnt);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TableSize; i++) begin
        shadow_tag[i] = TagFree;
        shadow_key[i] = '0;
        shadow_val[i] = '0;
      end
      used_cnt = 0;
      live_cnt = 0;
      mismatch_cnt = 0;
      expected_rsp_q.delete();
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      // a result leaves before the transaction taken in the same cycle
      if (done_o) begin
        if (expected_rsp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: status %0d key %h value %h slot %0d total %0d",
                     rsp_o.status, rsp_o.found_key, rsp_o.found_value, rsp_o.slot,
                     rsp_o.active_total);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_o.status !== want.status || rsp_o.found_key !== want.found_key ||
              rsp_o.found_value !== want.found_value || rsp_o.slot !== want.slot ||
              rsp_o.active_total !== want.active_total) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch exp: status %0d key %h value %h slot %0d total %0d",
                       want.status, want.found_key, want.found_value, want.slot,
                       want.active_total);
              $display("mismatch got: status %0d key %h value %h slot %0d total %0d",
                       rsp_o.status, rsp_o.found_key, rsp_o.found_value, rsp_o.slot,
                       rsp_o.active_total);
            end
          end
        end
      end
      if (start && !busy) expected_rsp_q.push_back(apply_op(req_i));
      errors_o <= mismatch_cnt;
      pending_o <= expected_rsp_q.size();
    end
  end

endmodule

### verif/tb_top.sv
// tb_top: stimulus and verdict for the quadratic probe hash table core.
// depends on qph_pkg, the core and qph_checker, which checks every result.

module tb_top;
  import qph_pkg::*;

  // generous bound, a slow correct run stays far below it
  localparam int Limit = 1000000;
  localparam int TargetItems = 1700;
  // highest quotient that keeps q * TableSize + home within 32 bits
  localparam int unsigned MaxQuot = 33818639;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;
  int   errors;
  int   pending;

  int          cycle_cnt;
  int          sent;
  int          kind_cnt [8];
  bit          idle_en;
  logic [31:0] key_pool [128];
  int          pool_len;

  quadratic_probe_hash_table_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  qph_checker checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // watchdog: a hang or a lost result ends the run here
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < Limit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  // one transaction: optional idle gap, then hold start until busy is low
  // at a rising edge. start is lowered here only when a gap follows, so it never
  // gets two assignments in one step
  task automatic issue(input req_t r);
    int gap;
    gap = 0;
    if (idle_en) begin
      while ($urandom_range(0, 99) < 37) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    kind_cnt[r.kind]++;
    sent++;
  endtask

  task automatic op(input logic [2:0] kind, input logic [31:0] key,
                    input logic [31:0] value, input logic [6:0] rank);
    req_t r;
    r.kind = kind;
    r.key = key;
    r.value = value;
    r.rank = rank;
    issue(r);
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // key pool for one phase: keys share a band of home slots from slot zero up to a
  // random bound, so that probe chains can grow long, high bits stay fully random
  task automatic fill_pool();
    int unsigned band;
    pool_len = $urandom_range(6, 110);
    band = $urandom_range(2, TableSize - 1);
    for (int i = 0; i < pool_len; i++)
      key_pool[i] = $urandom_range(0, MaxQuot) * TableSize + $urandom_range(0, band);
  endtask

  function automatic logic [31:0] pool_key();
    return key_pool[$urandom_range(0, pool_len - 1)];
  endfunction

  initial begin
    int pick;
    int phase_len;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    sent = 0;
    idle_en = 1'b1;
    for (int i = 0; i < 8; i++) kind_cnt[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, key extremes, collisions on home slot zero,
    // replace, tombstone then miss, tombstone reuse, rank edges, bad kinds
    op(KindFind,     32'h0000_0000, 32'h0000_0000, 7'd0);
    op(KindInsert,   32'h0000_0000, 32'h0000_0000, 7'd0);
    op(KindInsert,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
    op(KindInsert,   32'd127,       32'hA5A5_A5A5, 7'd0);
    op(KindInsert,   32'd254,       32'h1234_5678, 7'd0);
    op(KindInsert,   32'd127,       32'h5A5A_5A5A, 7'd0);
    op(KindFind,     32'd254,       32'h0000_0000, 7'd0);
    op(KindRemove,   32'd127,       32'h0000_0000, 7'd0);
    op(KindFind,     32'd127,       32'h0000_0000, 7'd0);
    op(KindRemove,   32'd127,       32'h0000_0000, 7'd0);
    op(KindInsert,   32'd381,       32'hDEAD_BEEF, 7'd0);
    op(KindFind,     32'hFFFF_FFFF, 32'h0000_0000, 7'd0);
    op(KindRetrieve, 32'h0000_0000, 32'h0000_0000, 7'd0);
    op(KindRetrieve, 32'h0000_0000, 32'h0000_0000, 7'd1);
    op(KindRetrieve, 32'h0000_0000, 32'h0000_0000, 7'd4);
    op(KindRetrieve, 32'h0000_0000, 32'h0000_0000, 7'd5);
    op(KindRetrieve, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
    op(3'd5,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
    op(3'd6,         32'h0000_0000, 32'h0000_0000, 7'd0);
    op(3'd7,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
    op(KindClear,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
    op(KindFind,     32'h0000_0000, 32'h0000_0000, 7'd0);
    drain();

    // random phases, each with its own key pool and ending in a clear
    while (sent < TargetItems) begin
      fill_pool();
      // a quiet window with back-to-back transactions
      idle_en = !(sent >= 700 && sent < 1000);
      // sometimes load the table hard so half-load refusals can show up
      if ($urandom_range(0, 2) == 0) begin
        repeat (70) op(KindInsert, pool_key(), $urandom(), 7'($urandom_range(0, 127)));
      end
      phase_len = $urandom_range(80, 200);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)
          op(KindInsert, pool_key(), $urandom(), 7'($urandom_range(0, 127)));
        else if (pick < 65)
          op(KindRemove, pool_key(), $urandom(), 7'($urandom_range(0, 127)));
        else if (pick < 82)
          op(KindFind, pool_key(), $urandom(), 7'($urandom_range(0, 127)));
        else if (pick < 90)
          op(KindRetrieve, $urandom(), $urandom(), 7'($urandom_range(0, 70)));
        else if (pick < 92)
          op(KindRetrieve, $urandom(), $urandom(), 7'($urandom_range(0, 127)));
        else if (pick < 97)
          // noise: keys outside the pool
          op(3'($urandom_range(0, 2)), $urandom(), $urandom(),
             7'($urandom_range(0, 127)));
        else if (pick < 99)
          op(3'($urandom_range(5, 7)), $urandom(), $urandom(),
             7'($urandom_range(0, 127)));
        else
          op(KindClear, $urandom(), $urandom(), 7'($urandom_range(0, 127)));
      end
      op(KindClear, $urandom(), $urandom(), 7'($urandom_range(0, 127)));
      drain();
    end

    // all accepted: wait for the tail, then a retrieve-length margin
    drain();
    repeat (TableSize + 16) @(posedge clk_i);

    $display("covered %0d transactions: %0d insert, %0d remove, %0d find, %0d retrieve,",
             sent, kind_cnt[KindInsert], kind_cnt[KindRemove], kind_cnt[KindFind],
             kind_cnt[KindRetrieve]);
    $display("  %0d clear, %0d unknown kind, %0d mismatches",
             kind_cnt[KindClear], kind_cnt[5] + kind_cnt[6] + kind_cnt[7], errors);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/qph_pkg.sv
design/qph_ram.sv
design/qph_mod.sv
design/quadratic_probe_hash_table_core.sv
design/qph_checker.sv
verif/qph_checker.sv
verif/tb_top.sv
